### src/lprd_pkg.sv
// ----------------------------------------------------------------------------
// lprd_pkg
// shared types and constants for the length-prefixed request deframer
// ----------------------------------------------------------------------------
package lprd_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_MESSAGE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ARGS    = 4'd1;

    localparam logic [30:0] MAX_MESSAGE_RESET = 31'd4096;
    localparam logic [15:0] MAX_ARGS_RESET    = 16'd1024;

    // bytes in every length or count field
    localparam logic [30:0] FIELD_BYTES = 31'd4;

    typedef enum logic [1:0] {
        PH_LEN    = 2'd0,
        PH_COUNT  = 2'd1,
        PH_ARGLEN = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EVT_BYTE      = 2'd0,
        EVT_EMPTY_ARG = 2'd1,
        EVT_EMPTY_REQ = 2'd2,
        EVT_ERROR     = 2'd3
    } evt_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_BAD_LENGTH  = 3'd1,
        ERR_SHORT_COUNT = 3'd2,
        ERR_TOO_MANY    = 3'd3,
        ERR_LEN_TRUNC   = 3'd4,
        ERR_STR_TRUNC   = 3'd5,
        ERR_EXTRA_DATA  = 3'd6
    } err_code_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_connection;
    } req_word_t;

    typedef struct packed {
        evt_kind_t  event_res;
        logic [7:0] arg_byte;
        logic [15:0] arg_index;
        logic       arg_last_byte;
        logic       request_end;
        err_code_t  error_code;
    } evt_word_t;

    typedef struct packed {
        logic [30:0] max_message;
        logic [15:0] max_args;
    } cfg_regs_t;

    // handshake between the pipeline registers and the parser
    typedef struct packed {
        logic go;
        logic res_valid;
    } stage_ctl_t;

endpackage

### src/lprd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lprd_cfg_regs
// limit registers written through the configuration channel
// ----------------------------------------------------------------------------
module lprd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [lprd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lprd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lprd_pkg::cfg_regs_t               regs
);
    import lprd_pkg::*;

    logic [30:0] max_message_reg;
    logic [15:0] max_args_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_message_reg <= MAX_MESSAGE_RESET;
            max_args_reg    <= MAX_ARGS_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_MAX_MESSAGE)
            begin
                max_message_reg <= cfg_data[30:0];
            end
            else if (cfg_index == REG_MAX_ARGS)
            begin
                max_args_reg <= cfg_data[15:0];
            end
        end
    end

    assign regs.max_message = max_message_reg;
    assign regs.max_args    = max_args_reg;

endmodule

### src/lprd_in_stage.sv
// ----------------------------------------------------------------------------
// lprd_in_stage
// input register holding one stream word for the parser
// ----------------------------------------------------------------------------
module lprd_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  lprd_pkg::req_word_t  req_data,
    input  logic                 advance,
    output logic                 held_valid,
    output lprd_pkg::req_word_t  held_data
);
    import lprd_pkg::*;

    logic      valid_reg;
    req_word_t data_reg;

    assign req_ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            data_reg <= req_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

### src/lprd_parser.sv
// ----------------------------------------------------------------------------
// lprd_parser
// framing state and single-pass decode of one stream word
// ----------------------------------------------------------------------------
module lprd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lprd_pkg::cfg_regs_t  cfg,
    input  lprd_pkg::req_word_t  cur,
    input  logic                 go,
    output logic                 res_valid,
    output lprd_pkg::evt_word_t  res
);
    import lprd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [23:0] shift_reg, shift_next;
    logic [30:0] rbl_reg, rbl_next;
    logic [15:0] args_reg, args_next;
    logic [15:0] arg_reg, arg_next;
    logic [30:0] sbl_reg, sbl_next;
    logic        closed_reg, closed_next;

    // state after an optional new-connection clear
    phase_t      eff_phase;
    logic [1:0]  eff_cnt;
    logic [23:0] eff_shift;
    logic [30:0] eff_rbl;
    logic [15:0] eff_args;
    logic [15:0] eff_arg;
    logic [30:0] eff_sbl;
    logic        eff_closed;

    logic [31:0] v;
    logic        done;
    logic [30:0] rbl_dec;
    logic [30:0] sbl_dec;
    logic [16:0] arg_inc;
    logic        rbl_short;

    logic        take_field, dec_rbl, dec_sbl, fin;
    logic        ld_rbl, ld_args, ld_sbl, arg_step, arg_zero;
    logic        emit, last, endf, fail;
    evt_kind_t   kind;
    err_code_t   err;
    phase_t      phase_target;

    always_comb
    begin
        eff_phase  = phase_reg;
        eff_cnt    = cnt_reg;
        eff_shift  = shift_reg;
        eff_rbl    = rbl_reg;
        eff_args   = args_reg;
        eff_arg    = arg_reg;
        eff_sbl    = sbl_reg;
        eff_closed = closed_reg;
        if (cur.new_connection)
        begin
            eff_phase  = PH_LEN;
            eff_cnt    = 2'd0;
            eff_shift  = 24'd0;
            eff_rbl    = 31'd0;
            eff_args   = 16'd0;
            eff_arg    = 16'd0;
            eff_sbl    = 31'd0;
            eff_closed = 1'b0;
        end
    end

    assign v         = {eff_shift, cur.data_byte};
    assign done      = (eff_cnt == 2'd3);
    assign rbl_dec   = (eff_rbl != 31'd0) ? eff_rbl - 31'd1 : eff_rbl;
    assign sbl_dec   = (eff_sbl != 31'd0) ? eff_sbl - 31'd1 : eff_sbl;
    assign arg_inc   = {1'b0, eff_arg} + 17'd1;
    assign rbl_short = (rbl_dec < FIELD_BYTES);

    // decode: what this word does
    always_comb
    begin
        take_field   = 1'b0;
        dec_rbl      = 1'b0;
        dec_sbl      = 1'b0;
        fin          = 1'b0;
        ld_rbl       = 1'b0;
        ld_args      = 1'b0;
        ld_sbl       = 1'b0;
        arg_step     = 1'b0;
        arg_zero     = 1'b0;
        emit         = 1'b0;
        last         = 1'b0;
        endf         = 1'b0;
        kind         = EVT_BYTE;
        err          = ERR_NONE;
        phase_target = eff_phase;
        if (!eff_closed)
        begin
            case (eff_phase)
                PH_LEN:
                begin
                    take_field = 1'b1;
                    if (done)
                    begin
                        if (v[31] || (v[30:0] > cfg.max_message))
                        begin
                            err = ERR_BAD_LENGTH;
                        end
                        else if (v < 32'd4)
                        begin
                            err = ERR_SHORT_COUNT;
                        end
                        else
                        begin
                            ld_rbl       = 1'b1;
                            phase_target = PH_COUNT;
                        end
                    end
                end
                PH_COUNT:
                begin
                    take_field = 1'b1;
                    dec_rbl    = 1'b1;
                    if (done)
                    begin
                        if (v > {16'd0, cfg.max_args})
                        begin
                            err = ERR_TOO_MANY;
                        end
                        else if (v == 32'd0)
                        begin
                            if (rbl_dec != 31'd0)
                            begin
                                err = ERR_EXTRA_DATA;
                            end
                            else
                            begin
                                emit         = 1'b1;
                                kind         = EVT_EMPTY_REQ;
                                endf         = 1'b1;
                                phase_target = PH_LEN;
                            end
                        end
                        else if (rbl_short)
                        begin
                            err = ERR_LEN_TRUNC;
                        end
                        else
                        begin
                            ld_args      = 1'b1;
                            arg_zero     = 1'b1;
                            phase_target = PH_ARGLEN;
                        end
                    end
                end
                PH_ARGLEN:
                begin
                    take_field = 1'b1;
                    dec_rbl    = 1'b1;
                    if (done)
                    begin
                        if (v > {1'b0, rbl_dec})
                        begin
                            err = ERR_STR_TRUNC;
                        end
                        else if (v == 32'd0)
                        begin
                            fin  = 1'b1;
                            kind = EVT_EMPTY_ARG;
                        end
                        else
                        begin
                            ld_sbl       = 1'b1;
                            phase_target = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    dec_rbl = 1'b1;
                    dec_sbl = 1'b1;
                    kind    = EVT_BYTE;
                    if (sbl_dec == 31'd0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    take_field = 1'b0;
                end
            endcase
        end

        // argument complete: next argument, request end, or framing error
        if (fin)
        begin
            if (arg_inc >= {1'b0, eff_args})
            begin
                if (rbl_dec != 31'd0)
                begin
                    err = ERR_EXTRA_DATA;
                end
                else
                begin
                    emit         = 1'b1;
                    last         = 1'b1;
                    endf         = 1'b1;
                    arg_zero     = 1'b1;
                    phase_target = PH_LEN;
                end
            end
            else if (rbl_short)
            begin
                err = ERR_LEN_TRUNC;
            end
            else
            begin
                emit         = 1'b1;
                last         = 1'b1;
                arg_step     = 1'b1;
                phase_target = PH_ARGLEN;
            end
        end
        fail = (err != ERR_NONE);
    end

    // next state
    always_comb
    begin
        phase_next  = fail ? eff_phase : phase_target;
        cnt_next    = take_field ? eff_cnt + 2'd1 : eff_cnt;
        shift_next  = take_field ? v[23:0] : eff_shift;
        rbl_next    = ld_rbl ? v[30:0] : (dec_rbl ? rbl_dec : eff_rbl);
        args_next   = ld_args ? v[15:0] : eff_args;
        sbl_next    = ld_sbl ? v[30:0] : (dec_sbl ? sbl_dec : eff_sbl);
        closed_next = eff_closed || fail;
        if (arg_zero)
        begin
            arg_next = 16'd0;
        end
        else if (arg_step)
        begin
            arg_next = arg_inc[15:0];
        end
        else
        begin
            arg_next = eff_arg;
        end
    end

    // result word
    always_comb
    begin
        res_valid         = emit || fail;
        res.event_res     = fail ? EVT_ERROR : kind;
        res.arg_byte      = (!fail && kind == EVT_BYTE) ? cur.data_byte : 8'd0;
        res.arg_index     = (!fail && (kind == EVT_BYTE || kind == EVT_EMPTY_ARG)) ?
                            eff_arg : 16'd0;
        res.arg_last_byte = !fail && last;
        res.request_end   = !fail && endf;
        res.error_code    = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN;
            cnt_reg    <= 2'd0;
            shift_reg  <= 24'd0;
            rbl_reg    <= 31'd0;
            args_reg   <= 16'd0;
            arg_reg    <= 16'd0;
            sbl_reg    <= 31'd0;
            closed_reg <= 1'b0;
        end
        else if (go)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
            rbl_reg    <= rbl_next;
            args_reg   <= args_next;
            arg_reg    <= arg_next;
            sbl_reg    <= sbl_next;
            closed_reg <= closed_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
        go && res_valid && res.event_res == EVT_ERROR |=> closed_reg)
        else $error("error result did not close the connection");

    a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        go && closed_reg && !cur.new_connection |-> !res_valid)
        else $error("result produced while closed");

    a_end_to_len: assert property (@(posedge clk) disable iff (!rst_n)
        go && res_valid && res.request_end |=> phase_reg == PH_LEN)
        else $error("request end did not return to length phase");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA && !closed_reg |-> sbl_reg != 31'd0)
        else $error("data phase with no string bytes left");
`endif

endmodule

### src/lprd_out_stage.sv
// ----------------------------------------------------------------------------
// lprd_out_stage
// result register toward the event channel
// ----------------------------------------------------------------------------
module lprd_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lprd_pkg::stage_ctl_t ctl,
    input  lprd_pkg::evt_word_t  res,
    output logic                 slot_free,
    output logic                 evt_valid,
    input  logic                 evt_ready,
    output lprd_pkg::evt_word_t  evt_data
);
    import lprd_pkg::*;

    logic      valid_reg;
    evt_word_t data_reg;

    assign slot_free = !valid_reg || evt_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.go)
        begin
            valid_reg <= ctl.res_valid;
        end
        else if (evt_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.go && ctl.res_valid)
        begin
            data_reg <= res;
        end
    end

    assign evt_valid = valid_reg;
    assign evt_data  = data_reg;

endmodule

### src/length_prefixed_request_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer_core
// splits a length-prefixed request stream into tagged argument byte events
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid/req_ready  | req_data   (byte, new conn)
//  evt     | out       | evt_valid/evt_ready  | evt_data   (event, byte, tags)
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data (limits)
//
//  one stream word per cycle unless evt_ready stalls the output; an accepted
//  word goes through the input register, then decode into the result register
//  reset leaves the parser waiting for a request length, limits 4096 / 1024
//  evt_ready low holds the result register, the parser and then the input
//  register; req_ready drops only when both registers are full
//  cfg_ready is always high; writes to unused indexes are ignored
// ----------------------------------------------------------------------------
module length_prefixed_request_deframer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  lprd_pkg::req_word_t               req_data,
    output logic                              evt_valid,
    input  logic                              evt_ready,
    output lprd_pkg::evt_word_t               evt_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lprd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lprd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lprd_pkg::*;

    cfg_regs_t  cfg;
    logic       held_valid;
    req_word_t  held_data;
    logic       slot_free;
    logic       advance;
    logic       res_valid;
    evt_word_t  res;
    stage_ctl_t ctl;

    // limits can always be written
    assign cfg_ready = 1'b1;

    // held word moves through decode when the result slot can take it
    assign advance       = held_valid && slot_free;
    assign ctl.go        = advance;
    assign ctl.res_valid = res_valid;

    lprd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    lprd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .advance    (advance),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    // framing state machine and per-word decode
    lprd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cur       (held_data),
        .go        (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    lprd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .res       (res),
        .slot_free (slot_free),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// feeds length-prefixed request streams through the deframer, byte by byte,
// and checks every event word against a parser model kept in step here
// ----------------------------------------------------------------------------
module testbench;
    import lprd_pkg::*;

    // cycles that a word may still be in flight after the last event came out
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // shapes of generated requests: well formed, one for each framing error, cut, or noise
    typedef enum int {
        REQ_GOOD,
        REQ_BAD_LEN,
        REQ_SHORT,
        REQ_MANY,
        REQ_NO_ROOM,
        REQ_STR_LONG,
        REQ_TRAILING,
        REQ_CUT,
        REQ_NOISE
    } req_shape_t;

    // one row of the directed table; fixed rows carry a hand-typed expectation
    typedef struct packed {
        logic [7:0] data_byte;
        logic       nc;
        logic       fixed;
        logic       fixed_has;
        evt_word_t  fixed_evt;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_word_t              req_data = '0;
    logic                   evt_valid;
    logic                   evt_ready = 1'b0;
    evt_word_t              evt_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    length_prefixed_request_deframer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // parser model state, advanced once per accepted stream word
    phase_t      pr_phase;
    logic [1:0]  pr_fcount;
    logic [31:0] pr_shift;
    logic [30:0] pr_req_left;
    logic [15:0] pr_args_exp;
    logic [15:0] pr_arg_idx;
    logic [30:0] pr_str_left;
    logic        pr_closed;

    // limits as the block should hold them
    logic [30:0] lim_message;
    logic [15:0] lim_args;

    // event words predicted but not yet seen on the output
    evt_word_t   pending_evts[$];
    stim_row_t   plan[$];

    idle_mode_t  idle_mode = IDLE_NONE;
    int          fail_count = 0;
    int          words_sent = 0;
    int          evts_checked = 0;
    int          kind_seen[4] = '{default: 0};
    int          code_seen[8] = '{default: 0};

    function automatic void clear_parser();
        pr_phase    = PH_LEN;
        pr_fcount   = '0;
        pr_shift    = '0;
        pr_req_left = '0;
        pr_args_exp = '0;
        pr_arg_idx  = '0;
        pr_str_left = '0;
        pr_closed   = 1'b0;
    endfunction

    function automatic evt_word_t pack_evt(evt_kind_t k, logic [7:0] b, logic [15:0] idx,
                                           logic last, logic fin, err_code_t code);
        evt_word_t e;
        e.event_res     = k;
        e.arg_byte      = b;
        e.arg_index     = idx;
        e.arg_last_byte = last;
        e.request_end   = fin;
        e.error_code    = code;
        return e;
    endfunction

    // first framing error closes the connection until the next new_connection
    function automatic evt_word_t reject(err_code_t code);
        pr_closed = 1'b1;
        return pack_evt(EVT_ERROR, 8'h00, 16'h0000, 1'b0, 1'b0, code);
    endfunction

    // current argument is complete: either the request ends or the next
    // length field must still fit in the body
    function automatic evt_word_t close_arg(evt_kind_t k, logic [7:0] b);
        logic [15:0] idx;
        int unsigned nxt;
        idx = pr_arg_idx;
        nxt = 32'(pr_arg_idx) + 1;
        if (nxt >= pr_args_exp)
        begin
            if (pr_req_left != 0)
                return reject(ERR_EXTRA_DATA);
            pr_phase   = PH_LEN;
            pr_arg_idx = '0;
            return pack_evt(k, b, idx, 1'b1, 1'b1, ERR_NONE);
        end
        if (pr_req_left < FIELD_BYTES)
            return reject(ERR_LEN_TRUNC);
        pr_arg_idx = nxt[15:0];
        pr_phase   = PH_ARGLEN;
        return pack_evt(k, b, idx, 1'b1, 1'b0, ERR_NONE);
    endfunction

    // big-endian field assembly, true once the fourth byte is in
    function automatic bit shift_in(logic [7:0] b);
        pr_shift  = {pr_shift[23:0], b};
        pr_fcount = pr_fcount + 2'd1;
        return pr_fcount == 2'd0;
    endfunction

    function automatic bit predict_word(input req_word_t w, output evt_word_t r);
        logic [31:0] v;
        r = '0;
        if (w.new_connection)
            clear_parser();
        if (pr_closed)
            return 1'b0;
        case (pr_phase)
            PH_COUNT:
            begin
                if (pr_req_left != 0)
                    pr_req_left = pr_req_left - 31'd1;
                if (!shift_in(w.data_byte))
                    return 1'b0;
                v = pr_shift;
                if (v > lim_args)
                begin
                    r = reject(ERR_TOO_MANY);
                    return 1'b1;
                end
                if (v == 0)
                begin
                    // zero arguments: the body must end right here
                    if (pr_req_left != 0)
                        r = reject(ERR_EXTRA_DATA);
                    else
                    begin
                        pr_phase = PH_LEN;
                        r = pack_evt(EVT_EMPTY_REQ, 8'h00, 16'h0000, 1'b0, 1'b1, ERR_NONE);
                    end
                    return 1'b1;
                end
                if (pr_req_left < FIELD_BYTES)
                begin
                    r = reject(ERR_LEN_TRUNC);
                    return 1'b1;
                end
                pr_args_exp = v[15:0];
                pr_arg_idx  = '0;
                pr_phase    = PH_ARGLEN;
                return 1'b0;
            end
            PH_ARGLEN:
            begin
                if (pr_req_left != 0)
                    pr_req_left = pr_req_left - 31'd1;
                if (!shift_in(w.data_byte))
                    return 1'b0;
                v = pr_shift;
                if (v > pr_req_left)
                begin
                    r = reject(ERR_STR_TRUNC);
                    return 1'b1;
                end
                if (v == 0)
                begin
                    r = close_arg(EVT_EMPTY_ARG, 8'h00);
                    return 1'b1;
                end
                pr_str_left = v[30:0];
                pr_phase    = PH_DATA;
                return 1'b0;
            end
            PH_DATA:
            begin
                if (pr_req_left != 0)
                    pr_req_left = pr_req_left - 31'd1;
                if (pr_str_left != 0)
                    pr_str_left = pr_str_left - 31'd1;
                if (pr_str_left == 0)
                    r = close_arg(EVT_BYTE, w.data_byte);
                else
                    r = pack_evt(EVT_BYTE, w.data_byte, pr_arg_idx, 1'b0, 1'b0, ERR_NONE);
                return 1'b1;
            end
            default:
            begin
                if (!shift_in(w.data_byte))
                    return 1'b0;
                v = pr_shift;
                // negative lengths count as invalid, like oversized ones
                if (v[31] || v > lim_message)
                begin
                    r = reject(ERR_BAD_LENGTH);
                    return 1'b1;
                end
                if (v < FIELD_BYTES)
                begin
                    r = reject(ERR_SHORT_COUNT);
                    return 1'b1;
                end
                pr_req_left = v[30:0];
                pr_phase    = PH_COUNT;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void add_row(logic [7:0] b, logic nc, logic fixed, logic has,
                                    evt_word_t e);
        stim_row_t row;
        row  = '{b, nc, fixed, has, e};
        plan = {plan, row};
    endfunction

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk)
    begin
        evt_ready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 81) ||
                       (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 36));
    end

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t ns: %s expected %0h got %0h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    // output side: every accepted event word is matched against the oldest
    // prediction, field by field
    always @(posedge clk)
    begin : evt_check
        evt_word_t want;
        if (rst_n && evt_valid && evt_ready)
        begin
            if (pending_evts.size() == 0)
            begin
                $display("%0t ns: event word %h with nothing expected", $time, evt_data);
                fail_count++;
            end
            else
            begin
                want = pending_evts.pop_front();
                check_field("event_res", 32'(want.event_res), 32'(evt_data.event_res));
                check_field("arg_byte", 32'(want.arg_byte), 32'(evt_data.arg_byte));
                check_field("arg_index", 32'(want.arg_index), 32'(evt_data.arg_index));
                check_field("arg_last_byte", 32'(want.arg_last_byte),
                            32'(evt_data.arg_last_byte));
                check_field("request_end", 32'(want.request_end),
                            32'(evt_data.request_end));
                check_field("error_code", 32'(want.error_code), 32'(evt_data.error_code));
                evts_checked++;
                kind_seen[want.event_res]++;
                code_seen[want.error_code]++;
            end
        end
    end

    // present one stream word at the falling edge, hold it until accepted,
    // then advance the model; valid is left high so back-to-back words flow
    task automatic send_word(input req_word_t w, input bit fixed, input bit fixed_has,
                             input evt_word_t fixed_evt);
        evt_word_t got;
        bit        has;
        while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 81) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 36))
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= w;
        do @(posedge clk); while (!req_ready);
        words_sent++;
        has = predict_word(w, got);
        if (fixed)
        begin
            has = fixed_has;
            got = fixed_evt;
        end
        if (has)
            pending_evts = {pending_evts, got};
        @(negedge clk);
    endtask

    // stop sending and wait for every predicted event to come out
    task automatic pause_stream(int extra);
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_evts.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // both limits, with random junk in the unused upper data bits
    task automatic write_limits(logic [30:0] mm, logic [15:0] ma);
        logic [CFG_DATA_W-1:0] d;
        d = {1'($urandom_range(0, 1)), mm};
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_MESSAGE;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        lim_message = d[30:0];
        @(negedge clk);
        d = {16'($urandom), ma};
        cfg_index <= REG_MAX_ARGS;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        lim_args = d[15:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one generated request: mostly well formed with random contents, the
    // rest aimed at each framing error, cut short, or plain line noise
    task automatic send_request();
        logic [7:0]  body[$];
        logic [7:0]  frame[$];
        int unsigned lens[$];
        logic [31:0] count_v;
        logic [31:0] declared;
        int unsigned nargs;
        int unsigned r;
        int unsigned extra;
        int unsigned total;
        req_shape_t  shape;
        bit          nc;
        req_word_t   w;
        r = $urandom_range(0, 99);
        shape = r < 65 ? REQ_GOOD : r < 70 ? REQ_BAD_LEN : r < 74 ? REQ_SHORT :
                r < 78 ? REQ_MANY : r < 83 ? REQ_NO_ROOM : r < 87 ? REQ_STR_LONG :
                r < 91 ? REQ_TRAILING : r < 96 ? REQ_CUT : REQ_NOISE;
        if (shape == REQ_NOISE)
        begin
            repeat ($urandom_range(1, 12))
            begin
                w.data_byte      = 8'($urandom);
                w.new_connection = ($urandom_range(0, 3) == 0);
                send_word(w, 1'b0, 1'b0, '0);
            end
            return;
        end
        nargs = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
        if ((shape == REQ_NO_ROOM || shape == REQ_STR_LONG) && nargs == 0)
            nargs = 1;
        repeat (nargs)
            lens = {lens, (($urandom_range(0, 9) == 0) ? $urandom_range(6, 40)
                                                       : $urandom_range(0, 5))};
        if (shape == REQ_STR_LONG && lens[0] == 0)
            lens[0] = 1;
        count_v = nargs;
        if (shape == REQ_MANY)
            count_v = $urandom_range(0, 1) ? {16'h0000, lim_args} + $urandom_range(1, 4)
                                           : $urandom;
        for (int s = 24; s >= 0; s -= 8)
            body = {body, count_v[s +: 8]};
        foreach (lens[i])
        begin
            for (int s = 24; s >= 0; s -= 8)
                body = {body, 8'(lens[i] >> s)};
            repeat (lens[i]) body = {body, 8'($urandom)};
        end
        declared = body.size();
        case (shape)
            REQ_BAD_LEN:
                declared = $urandom_range(0, 1) ? {1'b1, 31'($urandom)}
                                                : {1'b0, lim_message} + $urandom_range(1, 3);
            REQ_SHORT:
                declared = $urandom_range(0, 3);
            REQ_NO_ROOM:
                // body ends less than a length field after the count or arg 0
                declared = 4 + (nargs >= 2 ? 4 + lens[0] : 0) + $urandom_range(0, 3);
            REQ_STR_LONG:
                declared = 8 + $urandom_range(0, lens[0] - 1);
            REQ_TRAILING:
            begin
                extra = $urandom_range(1, 3);
                declared = body.size() + extra;
                repeat (extra) body = {body, 8'($urandom)};
            end
            default:
                ;
        endcase
        for (int s = 24; s >= 0; s -= 8)
            frame = {frame, declared[s +: 8]};
        foreach (body[i])
            frame = {frame, body[i]};
        total = frame.size();
        if (shape == REQ_CUT)
            total = $urandom_range(1, frame.size() - 1);
        // reopen the connection whenever the parser is not cleanly between
        // requests, and now and then anyway
        nc = pr_closed || pr_phase != PH_LEN || pr_fcount != 0 || $urandom_range(0, 19) == 0;
        for (int i = 0; i < total; i++)
        begin
            w.data_byte      = frame[i];
            w.new_connection = (i == 0) && nc;
            send_word(w, 1'b0, 1'b0, '0);
        end
    endtask

    // settle, load limits, then random requests until enough words went in
    task automatic run_phase(logic [30:0] mm, logic [15:0] ma, idle_mode_t mode, int n);
        int goal;
        pause_stream(SETTLE_CYCLES);
        write_limits(mm, ma);
        idle_mode = mode;
        goal = words_sent + n;
        while (words_sent < goal)
        begin
            send_request();
            // occasional full drain with the stream halted mid-phase
            if ($urandom_range(0, 49) == 0)
                pause_stream(0);
        end
    endtask

    initial
    begin : run
        req_word_t w;
        evt_word_t err_len;
        evt_word_t err_short;
        clear_parser();
        lim_message = MAX_MESSAGE_RESET;
        lim_args    = MAX_ARGS_RESET;
        err_len     = pack_evt(EVT_ERROR, 8'h00, 16'h0000, 1'b0, 1'b0, ERR_BAD_LENGTH);
        err_short   = pack_evt(EVT_ERROR, 8'h00, 16'h0000, 1'b0, 1'b0, ERR_SHORT_COUNT);

        // directed table at reset limits (4096 / 1024)
        //       byte   nc    fixed has   expectation
        // negative length, then a byte swallowed by the closed connection
        add_row(8'h80, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, err_len);
        add_row(8'hff, 1'b0, 1'b1, 1'b0, '0);
        // new connection, body length 3 leaves no room for the count
        add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b1, 1'b1, err_short);
        // new connection, one argument of two bytes ff 00
        add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h0a, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h02, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        // length one above the limit
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h10, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b1, 1'b1, err_len);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            w.data_byte      = plan[i].data_byte;
            w.new_connection = plan[i].nc;
            send_word(w, plan[i].fixed, plan[i].fixed_has, plan[i].fixed_evt);
        end

        // limit settings: reset, widest, zero, tight, reset again
        run_phase(MAX_MESSAGE_RESET, MAX_ARGS_RESET, IDLE_NONE, 150);
        run_phase(31'h7fff_ffff, 16'hffff, IDLE_SENDER, 150);
        run_phase(31'd0, 16'd0, IDLE_RECEIVER, 50);
        run_phase(31'd48, 16'd3, IDLE_BOTH, 170);
        run_phase(MAX_MESSAGE_RESET, MAX_ARGS_RESET, IDLE_RECEIVER, 150);

        pause_stream(SETTLE_CYCLES);
        if (pending_evts.size() != 0)
        begin
            $display("%0t ns: %0d expected event words never arrived", $time,
                     pending_evts.size());
            fail_count++;
        end

        $display("covered %0d stream words over five limit settings, %0d events checked",
                 words_sent, evts_checked);
        $display("events byte/empty arg/empty req/error %0d/%0d/%0d/%0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("error codes 1-6: %0d %0d %0d %0d %0d %0d", code_seen[1],
                 code_seen[2], code_seen[3], code_seen[4], code_seen[5], code_seen[6]);
        if (fail_count == 0)
            $display("length_prefixed_request_deframer_core verification clean");
        else
            $display("length_prefixed_request_deframer_core verification failed");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("%0t ns: timeout", $time);
        $display("length_prefixed_request_deframer_core verification failed");
        $finish;
    end

endmodule

### filelist.f
src/lprd_pkg.sv
src/lprd_cfg_regs.sv
src/lprd_in_stage.sv
src/lprd_parser.sv
src/lprd_out_stage.sv
src/length_prefixed_request_deframer_core.sv
tb/testbench.sv
